// ===== design/work_stealing_deque_macros.svh =====
// Assertion helpers used by the checking file of the deque, wsd_checker.
`ifndef WORK_STEALING_DEQUE_MACROS_SVH
`define WORK_STEALING_DEQUE_MACROS_SVH

// A plain property, sampled on the rising clock and ignored during reset.
`define WSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A signal must hold its value while its channel is stalled.
`define WSD_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error(msg);

`endif

// ===== design/wsd_pkg.sv =====
`default_nettype none

package wsd_pkg;

  // Sizes of the deque.
  localparam int CAPACITY  = 256;
  localparam int ITEM_BITS = 64;
  localparam int DATA_W    = 64;
  localparam int CNT_W     = 32;
  localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Only the low ITEM_BITS bits of an item word are kept.
  localparam logic [DATA_W-1:0] ITEM_MASK = {DATA_W{1'b1}} >> (DATA_W - ITEM_BITS);

  // Slot of the highest count value, reached when a counter wraps downward.
  localparam logic [SLOT_W-1:0] WRAP_SLOT = SLOT_W'(64'hFFFF_FFFF % CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    MODE_PUSH      = 2'd0,
    MODE_TAKE_TAIL = 2'd1,
    MODE_TAKE_HEAD = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_req;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/wsd_req_if.sv =====
`default_nettype none

// Request channel: one operation on the deque.
interface wsd_req_if;
  import wsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [DATA_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

// ===== design/wsd_rsp_if.sv =====
`default_nettype none

// Response channel: the outcome of one operation.
interface wsd_rsp_if;
  import wsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] taken_value;

  modport source (output valid, output status, output taken_value, input ready);
  modport sink (input valid, input status, input taken_value, output ready);
endinterface

`default_nettype wire

// ===== design/work_stealing_deque.sv =====
// Channel   Direction  Payload
// req       in         mode (2 bits), push_value (64 bits)
// rsp       out        status (2 bits), taken_value (64 bits)
//
// Every item gives one response. After the item is accepted, the execute step
// updates the pointers and accesses the buffer, and the load step loads the
// registered read data into the output register.
// A new item is accepted only in the idle state, so it waits until the
// controller's idle, execute and load sequence for the last item is through.
// Reset clears head and tail to zero; the buffer is not cleared.
// A stalled response holds the controller in its load step until the output
// frees, and no new item is accepted meanwhile.
`default_nettype none

module work_stealing_deque (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wsd_req_if.sink    req,
  wsd_rsp_if.source  rsp
);
  import wsd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  wsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  wsd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (req.mode),
    .push_value_i  (req.push_value),
    .rsp_valid_o   (rsp.valid),
    .rsp_ready_i   (rsp.ready),
    .status_o      (rsp.status),
    .taken_value_o (rsp.taken_value),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

// ===== design/wsd_ctrl.sv =====
`default_nettype none

module wsd_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic req_valid_i,
  output logic                     req_ready_o,
  output wsd_pkg::ctrl_cmd_t       cmd_o,
  input  wire wsd_pkg::dp_stat_t   stat_i
);
  import wsd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   ready_q;

  // State and the registered ready flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i && ready_q) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign req_ready_o = ready_q;

  // Commands to the datapath.
  always_comb begin
    cmd_o.latch_req = req_valid_i && ready_q;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.load_out  = (state_q == S_LOAD) && stat_i.out_free;
  end

endmodule

`default_nettype wire

// ===== design/wsd_datapath.sv =====
`default_nettype none

module wsd_datapath (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic [1:0] mode_i,
  input  wire                logic [wsd_pkg::DATA_W-1:0] push_value_i,
  output logic                     rsp_valid_o,
  input  wire                logic rsp_ready_i,
  output logic [1:0]               status_o,
  output logic [wsd_pkg::DATA_W-1:0] taken_value_o,
  input  wire wsd_pkg::ctrl_cmd_t  cmd_i,
  output wsd_pkg::dp_stat_t        stat_o
);
  import wsd_pkg::*;

  // Slot arithmetic that follows a 32-bit counter modulo the capacity.
  function automatic logic [SLOT_W-1:0] slot_inc(logic [CNT_W-1:0] cnt,
                                                 logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (cnt == {CNT_W{1'b1}}) begin
      res = '0;
    end else if (slot == LAST_SLOT) begin
      res = '0;
    end else begin
      res = slot + SLOT_W'(1);
    end
    return res;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(logic [CNT_W-1:0] cnt,
                                                 logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (cnt == '0) begin
      res = WRAP_SLOT;
    end else if (slot == '0) begin
      res = LAST_SLOT;
    end else begin
      res = slot - SLOT_W'(1);
    end
    return res;
  endfunction

  // Latched request.
  mode_e             mode_q;
  logic [DATA_W-1:0] value_q;

  // Deque pointers with their slot positions.
  logic [CNT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [SLOT_W-1:0] head_slot_q, head_slot_d;
  logic [SLOT_W-1:0] tail_slot_q, tail_slot_d;

  // Result of the executed operation, waiting for the read data.
  status_e           res_status_q, res_status_d;
  logic              take_ok_q, take_ok_d;

  // Buffer.
  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;
  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] rd_addr;

  // Output register.
  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_taken_q;

  logic [CNT_W-1:0]  occupancy;
  logic [SLOT_W-1:0] tail_prev_slot;

  assign occupancy      = tail_q - head_q;
  assign tail_prev_slot = slot_dec(tail_q, tail_slot_q);

  // Capture the request on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      mode_q  <= mode_e'(mode_i);
      value_q <= push_value_i & ITEM_MASK;
    end
  end

  // Pointer update and buffer access for the latched operation.
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    head_slot_d  = head_slot_q;
    tail_slot_d  = tail_slot_q;
    res_status_d = res_status_q;
    take_ok_d    = take_ok_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head_slot_q;
    if (cmd_i.exec) begin
      res_status_d = ST_EMPTY;
      take_ok_d    = 1'b0;
      unique case (mode_q)
        MODE_PUSH: begin
          if (occupancy >= CNT_W'(CAPACITY)) begin
            res_status_d = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            tail_d       = tail_q + CNT_W'(1);
            tail_slot_d  = slot_inc(tail_q, tail_slot_q);
            res_status_d = ST_OK;
          end
        end
        MODE_TAKE_TAIL: begin
          if (occupancy != '0) begin
            rd_en        = 1'b1;
            rd_addr      = tail_prev_slot;
            take_ok_d    = 1'b1;
            res_status_d = ST_OK;
            // The last item leaves through the head side.
            if (occupancy == CNT_W'(1)) begin
              head_d      = head_q + CNT_W'(1);
              head_slot_d = slot_inc(head_q, head_slot_q);
            end else begin
              tail_d      = tail_q - CNT_W'(1);
              tail_slot_d = tail_prev_slot;
            end
          end
        end
        MODE_TAKE_HEAD: begin
          if (occupancy != '0) begin
            rd_en        = 1'b1;
            rd_addr      = head_slot_q;
            take_ok_d    = 1'b1;
            res_status_d = ST_OK;
            head_d       = head_q + CNT_W'(1);
            head_slot_d  = slot_inc(head_q, head_slot_q);
          end
        end
        default: begin
          res_status_d = ST_EMPTY;
        end
      endcase
    end
  end

  // Pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      head_slot_q <= '0;
      tail_slot_q <= '0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      head_slot_q <= head_slot_d;
      tail_slot_q <= tail_slot_d;
    end
  end

  // Result of the operation until the output register takes it.
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    take_ok_q    <= take_ok_d;
  end

  // Buffer with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_slot_q] <= value_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_taken_q  <= take_ok_q ? (rd_data_q & ITEM_MASK) : '0;
    end
  end

  assign stat_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign taken_value_o   = out_taken_q;

endmodule

`default_nettype wire

// ===== design/wsd_checker.sv =====
`default_nettype none

`include "work_stealing_deque_macros.svh"

module wsd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire logic [1:0] rsp_status_i,
  input wire logic [wsd_pkg::DATA_W-1:0] rsp_taken_value_i
);
  import wsd_pkg::*;

  // A stalled response keeps its status and its item.
  `WSD_ASSERT_HOLD(a_hold_status, rsp_valid_i, rsp_ready_i, rsp_status_i, "status changed while stalled")
  `WSD_ASSERT_HOLD(a_hold_taken, rsp_valid_i, rsp_ready_i, rsp_taken_value_i, "item changed while stalled")

  // Only the defined status codes appear.
  `WSD_ASSERT(a_status_legal, rsp_valid_i |-> (rsp_status_i == ST_OK || rsp_status_i == ST_FULL || rsp_status_i == ST_EMPTY), "undefined status code")

  // A refused operation returns no item.
  `WSD_ASSERT(a_refused_zero, (rsp_valid_i && rsp_status_i != ST_OK) |-> (rsp_taken_value_i == '0), "refused operation returned an item")

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_status_i      (rsp.status),
  .rsp_taken_value_i (rsp.taken_value)
);

`default_nettype wire
